>>> hdl/tvl_pkg.sv
// Shared constants and types for the tiled voxel layout remap block.
`default_nettype none

package tvl_pkg;

  // Default largest volume extent per axis.
  localparam int MAX_DIM_DEF = 1024;

  // Fixed field widths.
  localparam int SIZE_W = 11;
  localparam int WORD_W = 32;
  localparam int DEST_W = 30;
  localparam int CFG_IDX_W = 2;

  // Tile edge is fixed at 8 voxels.
  localparam int TILE_LOG = 3;
  localparam int INTRA_W = 3 * TILE_LOG;
  // Tile id bits that survive the 30-bit mask after scaling by 512.
  localparam int TID_W = DEST_W - INTRA_W;
  // Tile count per axis: ceil(2047 / 8) = 256 needs 9 bits.
  localparam int NT_W = SIZE_W + 1 - TILE_LOG;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RST = 11'd8;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL1 = 4'b0010,
    ST_MUL2 = 4'b0100,
    ST_DONE = 4'b1000
  } tvl_state_t;

endpackage

`default_nettype wire

>>> hdl/tiled_voxel_layout_remap_core.sv
// Tiled voxel layout remap: linear voxel stream to 8x8x8 tiled destination index.
//
// Usage: set size_x/size_y/size_z through the cfg write port while idle, then
// stream voxel words on in_* (x fastest, then y, then z). Each word comes back
// on out_* with its index in the tiled array (tiles row-major, voxels inside a
// tile row-major); out_volume_end marks the last voxel, after which the
// coordinates wrap to zero. Sizes of 0 count as 1, sizes above MAX_DIM as
// MAX_DIM.
// The tile id goes through two passes of one shared multiply-add unit
// ((tz*nty + ty)*ntx + tx), and in_stall is high from the accepting edge until the
// result is moved to the output register: no new word is taken before then.
// A finished result waits in the output register while out_stall is high; the
// next word is accepted and worked on meanwhile, and holds in its last step
// until the output register frees up.
// Reset: synchronous, active low; sizes return to 8, coordinates to zero, no
// word is in flight and out_valid is low.
`default_nettype none

module tiled_voxel_layout_remap_core #(
  parameter int MAX_DIM = tvl_pkg::MAX_DIM_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [tvl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tvl_pkg::SIZE_W-1:0]     cfg_data,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [tvl_pkg::WORD_W-1:0]     in_voxel_word,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [tvl_pkg::DEST_W-1:0]     out_dest_index,
  output logic      [tvl_pkg::WORD_W-1:0]     out_voxel_out,
  output logic                                out_volume_end
);

  localparam int POS_W = $clog2(MAX_DIM);
  localparam int TC_W  = (POS_W > tvl_pkg::TILE_LOG) ? POS_W - tvl_pkg::TILE_LOG : 1;
  localparam int CW    = ((POS_W + 1 > tvl_pkg::SIZE_W) ? POS_W + 1 : tvl_pkg::SIZE_W) + 1;
  localparam int TL    = tvl_pkg::TILE_LOG;
  localparam int TID_W = tvl_pkg::TID_W;
  localparam int NT_W  = tvl_pkg::NT_W;

  // config registers
  logic [tvl_pkg::SIZE_W-1:0] size_x_r, size_y_r, size_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= tvl_pkg::SIZE_RST;
      size_y_r <= tvl_pkg::SIZE_RST;
      size_z_r <= tvl_pkg::SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tvl_pkg::REG_SIZE_X: size_x_r <= cfg_data;
        tvl_pkg::REG_SIZE_Y: size_y_r <= cfg_data;
        tvl_pkg::REG_SIZE_Z: size_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [CW-1:0] clamp_size(input logic [tvl_pkg::SIZE_W-1:0] s);
    logic [CW-1:0] se;
    se = CW'(s);
    if (se == '0) begin
      return CW'(1);
    end else if (se > CW'(MAX_DIM)) begin
      return CW'(MAX_DIM);
    end
    return se;
  endfunction

  logic [CW-1:0]   sx_c, sy_c, sz_c;
  logic [CW-1:0]   tx_sum, ty_sum;
  logic [NT_W-1:0] ntx_c, nty_c;

  assign sx_c   = clamp_size(size_x_r);
  assign sy_c   = clamp_size(size_y_r);
  assign sz_c   = clamp_size(size_z_r);
  assign tx_sum = sx_c + CW'(7);
  assign ty_sum = sy_c + CW'(7);
  assign ntx_c  = NT_W'(tx_sum >> TL);
  assign nty_c  = NT_W'(ty_sum >> TL);

  // sequencer
  tvl_pkg::tvl_state_t state_r, state_nxt;
  logic in_acc, out_free;

  assign in_stall = (state_r != tvl_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tvl_pkg::ST_IDLE: if (in_acc) state_nxt = tvl_pkg::ST_MUL1;
      tvl_pkg::ST_MUL1: state_nxt = tvl_pkg::ST_MUL2;
      tvl_pkg::ST_MUL2: state_nxt = tvl_pkg::ST_DONE;
      tvl_pkg::ST_DONE: if (out_free) state_nxt = tvl_pkg::ST_IDLE;
      default:          state_nxt = tvl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tvl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // coordinate counters
  logic [POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [POS_W-1:0] pos_x_nxt, pos_y_nxt, pos_z_nxt;
  logic [CW-1:0]    x1, y1, z1;
  logic             last_x, last_y, last_z;

  assign x1     = CW'(pos_x_r) + CW'(1);
  assign y1     = CW'(pos_y_r) + CW'(1);
  assign z1     = CW'(pos_z_r) + CW'(1);
  assign last_x = (x1 >= sx_c);
  assign last_y = (y1 >= sy_c);
  assign last_z = (z1 >= sz_c);

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    if (!last_x) begin
      pos_x_nxt = pos_x_r + POS_W'(1);
    end else begin
      pos_x_nxt = '0;
      if (!last_y) begin
        pos_y_nxt = pos_y_r + POS_W'(1);
      end else begin
        pos_y_nxt = '0;
        pos_z_nxt = last_z ? '0 : pos_z_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
    end else if (in_acc) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
    end
  end

  // item capture
  logic [tvl_pkg::WORD_W-1:0]  word_r;
  logic                        end_r;
  logic [tvl_pkg::INTRA_W-1:0] intra_r;
  logic [TC_W-1:0]             tx_r, ty_r, tz_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      word_r  <= in_voxel_word;
      end_r   <= last_x && last_y && last_z;
      intra_r <= {pos_z_r[TL-1:0], pos_y_r[TL-1:0], pos_x_r[TL-1:0]};
      tx_r    <= TC_W'(pos_x_r >> TL);
      ty_r    <= TC_W'(pos_y_r >> TL);
      tz_r    <= TC_W'(pos_z_r >> TL);
    end
  end

  // shared multiply-add: pass 1 tz*nty+ty, pass 2 acc*ntx+tx
  logic [TID_W-1:0] mac_a, mac_c, mac_acc;
  logic [NT_W-1:0]  mac_b;
  logic             mac_en, pass1;

  assign pass1  = (state_r == tvl_pkg::ST_MUL1);
  assign mac_en = pass1 || (state_r == tvl_pkg::ST_MUL2);
  assign mac_a  = pass1 ? TID_W'(tz_r) : mac_acc;
  assign mac_b  = pass1 ? nty_c : ntx_c;
  assign mac_c  = pass1 ? TID_W'(ty_r) : TID_W'(tx_r);

  tvl_mac #(
    .A_W (TID_W),
    .B_W (NT_W)
  ) u_mac (
    .clk (clk),
    .en  (mac_en),
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_c),
    .acc (mac_acc)
  );

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic                        load_out;
  logic [tvl_pkg::DEST_W-1:0]  out_dest_r;
  logic [tvl_pkg::WORD_W-1:0]  out_word_r;
  logic                        out_end_r;

  assign load_out = (state_r == tvl_pkg::ST_DONE) && out_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_dest_r <= {mac_acc, intra_r};
      out_word_r <= word_r;
      out_end_r  <= end_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dest_index = out_dest_r;
  assign out_voxel_out  = out_word_r;
  assign out_volume_end = out_end_r;

  // checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == tvl_pkg::ST_MUL1))
    else $error("accepted word did not start the multiply passes");

  a_x_steps: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (pos_x_r == '0) || (pos_x_r == $past(pos_x_r) + POS_W'(1)))
    else $error("x coordinate neither stepped nor wrapped");

  a_load_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid) && $past(rst_n)) |-> $past(state_r == tvl_pkg::ST_DONE))
    else $error("output word appeared without a finished item");

endmodule

`default_nettype wire

>>> hdl/tvl_mac.sv
// Shared multiply-add unit with its accumulator register.
`default_nettype none

module tvl_mac #(
  parameter int A_W = tvl_pkg::TID_W,
  parameter int B_W = tvl_pkg::NT_W
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [A_W-1:0] a,
  input  wire logic [B_W-1:0] b,
  input  wire logic [A_W-1:0] c,
  output logic      [A_W-1:0] acc
);

  logic [A_W+B_W-1:0] prod;
  logic [A_W-1:0]     acc_r;
  logic [A_W-1:0]     acc_nxt;

  assign prod    = a * b;
  // Result is wanted modulo 2^A_W only.
  assign acc_nxt = prod[A_W-1:0] + c;
  assign acc     = acc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> test/tvl_remap_checker.sv
// Checker for the tiled voxel remap block: predicts each word's tiled index and compares.
`timescale 1ns / 1ps

module tvl_remap_checker
  import tvl_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [WORD_W-1:0]     in_voxel_word,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [DEST_W-1:0]     out_dest_index,
  input  logic [WORD_W-1:0]     out_voxel_out,
  input  logic                  out_volume_end,
  output int unsigned           mismatches,
  output int unsigned           in_flight
);

  localparam int TILE = 1 << TILE_LOG;

  typedef struct packed {
    logic [DEST_W-1:0] dest;
    logic [WORD_W-1:0] word;
    logic              last;
  } placed_voxel_t;

  placed_voxel_t     awaited_voxels[$];
  logic [SIZE_W-1:0] size_x, size_y, size_z;
  int unsigned       px, py, pz;

  initial begin
    mismatches = 0;
    in_flight  = 0;
  end

  function automatic int unsigned extent(input logic [SIZE_W-1:0] s);
    if (s == '0) return 1;
    if (s > MAX_DIM) return MAX_DIM;
    return 32'(s);
  endfunction

  // Places the word at the current coordinates, then steps x, y, z with carry.
  function automatic placed_voxel_t place_voxel(input logic [WORD_W-1:0] w);
    int unsigned     ex, ey, ez;
    longint unsigned tiles_x, tiles_y, tile_id, slot;
    placed_voxel_t   r;
    ex = extent(size_x);
    ey = extent(size_y);
    ez = extent(size_z);
    tiles_x = 64'((ex + TILE - 1) / TILE);
    tiles_y = 64'((ey + TILE - 1) / TILE);
    tile_id = (64'(pz / TILE) * tiles_y + 64'(py / TILE)) * tiles_x + 64'(px / TILE);
    slot = tile_id * TILE * TILE * TILE
           + 64'(((pz % TILE) * TILE + py % TILE) * TILE + px % TILE);
    r.dest = slot[DEST_W-1:0];
    r.word = w;
    r.last = (px + 1 >= ex) && (py + 1 >= ey) && (pz + 1 >= ez);
    // a coordinate at or past a shrunk extent counts as the last on its axis
    if (px + 1 < ex) begin
      px++;
    end else begin
      px = 0;
      if (py + 1 < ey) begin
        py++;
      end else begin
        py = 0;
        if (pz + 1 < ez) pz++;
        else pz = 0;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    placed_voxel_t got, want;
    int unsigned   bad;
    bad = 0;
    if (!rst_n) begin
      size_x = SIZE_RST;
      size_y = SIZE_RST;
      size_z = SIZE_RST;
      px = 0;
      py = 0;
      pz = 0;
      awaited_voxels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SIZE_X: size_x = cfg_data;
          REG_SIZE_Y: size_y = cfg_data;
          REG_SIZE_Z: size_z = cfg_data;
          default: ;
        endcase
      end
      // retire before predicting: a word can never come back on its own edge
      if (out_valid && !out_stall) begin
        got = '{dest: out_dest_index, word: out_voxel_out, last: out_volume_end};
        if (awaited_voxels.size() == 0) begin
          $display("%0t: unexpected word, expected none, got dest %0d word %h end %0b",
                   $time, got.dest, got.word, got.last);
          bad++;
        end else begin
          want = awaited_voxels.pop_front();
          if (got.dest !== want.dest) begin
            $display("%0t: dest_index expected %0d, got %0d", $time, want.dest, got.dest);
            bad++;
          end
          if (got.word !== want.word) begin
            $display("%0t: voxel_out expected %h, got %h", $time, want.word, got.word);
            bad++;
          end
          if (got.last !== want.last) begin
            $display("%0t: volume_end expected %0b, got %0b", $time, want.last, got.last);
            bad++;
          end
        end
      end
      if (in_valid && !in_stall) awaited_voxels.push_back(place_voxel(in_voxel_word));
    end
    mismatches <= mismatches + bad;
    in_flight  <= awaited_voxels.size();
  end

endmodule

>>> test/tiled_voxel_layout_remap_core_test.sv
// Testbench top for the tiled voxel remap block: stimulus, stalls, timeout and verdict.
`timescale 1ns / 1ps

module tiled_voxel_layout_remap_core_test;
  import tvl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_WORDS = 900;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SIZE_X;
  logic [SIZE_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic [WORD_W-1:0]    in_voxel_word = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall, out_valid, out_volume_end;
  logic [DEST_W-1:0]    out_dest_index;
  logic [WORD_W-1:0]    out_voxel_out;
  int unsigned          mismatches, in_flight;
  logic                 bulk_phase = 1'b0;
  int unsigned          cycles = 0;
  int unsigned          burst_left = 0;

  tiled_voxel_layout_remap_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_voxel_word(in_voxel_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_dest_index(out_dest_index),
    .out_voxel_out(out_voxel_out), .out_volume_end(out_volume_end)
  );

  tvl_remap_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_voxel_word(in_voxel_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_dest_index(out_dest_index),
    .out_voxel_out(out_voxel_out), .out_volume_end(out_volume_end),
    .mismatches(mismatches), .in_flight(in_flight)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: segments of free flow, random stalls and long hold-offs.
  initial begin : rx_side
    int mode, span, odds;
    bit held;
    held = 1'b0;
    forever begin
      if (bulk_phase && !held) mode = 9;
      else mode = $urandom_range(0, 9);
      case (mode)
        0, 1, 2: begin
          span = $urandom_range(5, 60);
          out_stall <= 1'b0;
          repeat (span) @(posedge clk);
        end
        9: begin
          // long hold-off: the block backs up and stalls its input
          held = 1'b1;
          span = $urandom_range(80, 200);
          out_stall <= 1'b1;
          repeat (span) @(posedge clk);
        end
        default: begin
          span = $urandom_range(10, 80);
          odds = $urandom_range(10, 80);
          repeat (span) begin
            out_stall <= ($urandom_range(0, 99) < odds);
            @(posedge clk);
          end
        end
      endcase
    end
  end

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Offers one word and waits for it to be taken; bursts end in a random gap.
  task automatic send_voxel(input logic [WORD_W-1:0] w);
    in_valid      <= 1'b1;
    in_voxel_word <= w;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 20);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(0, WORD_W - 1);
      3: return ~(32'd1 << $urandom_range(0, WORD_W - 1));
      default: return $urandom;
    endcase
  endfunction

  // Mostly small extents so volumes finish often, with tile edges and range ends.
  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 11'd2047;
      2: return 11'd1024;
      3: return 11'd1025;
      4: return 11'd1023;
      5, 6: return 11'd8;
      7: return 11'd9;
      8: return 11'd16;
      9: return 11'd17;
      default: return SIZE_W'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin : stimulus
    int n, total;
    bit deep_done;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset extents 8x8x8
    send_voxel('0);
    send_voxel('1);
    send_voxel(32'ha5a5a5a5);
    in_valid <= 1'b0;
    wait_drained();
    // zero extents act as one, and x already sits past the new extent
    write_cfg(REG_SIZE_X, '0);
    write_cfg(REG_SIZE_Y, '0);
    write_cfg(REG_SIZE_Z, '0);
    cfg_we <= 1'b0;
    send_voxel(32'h5a5a5a5a);
    send_voxel(32'h80000001);
    send_voxel(32'h7ffffffe);
    in_valid <= 1'b0;
    wait_drained();
    write_cfg(REG_UNUSED, 11'd2047);
    cfg_we <= 1'b0;
    send_voxel(32'h0000ffff);
    send_voxel(32'hffff0000);
    in_valid <= 1'b0;
    wait_drained();
    // oversize extents clamp to the max
    write_cfg(REG_SIZE_X, 11'd2047);
    write_cfg(REG_SIZE_Y, 11'd2047);
    write_cfg(REG_SIZE_Z, 11'd2047);
    cfg_we <= 1'b0;
    repeat (4) send_voxel(pick_word());
    in_valid <= 1'b0;
    wait_drained();
    // x crosses a tile edge, then the volume wraps
    write_cfg(REG_SIZE_X, 11'd9);
    write_cfg(REG_SIZE_Y, 11'd2);
    write_cfg(REG_SIZE_Z, 11'd1);
    cfg_we <= 1'b0;
    repeat (14) send_voxel(pick_word());
    in_valid <= 1'b0;

    bulk_phase <= 1'b1;
    total = 0;
    deep_done = 1'b0;
    while (total < RANDOM_WORDS) begin
      wait_drained();
      if (!deep_done && total > 300) begin
        // walk z deep, then widen x and y so the tile id gets large
        deep_done = 1'b1;
        write_cfg(REG_SIZE_X, 11'd1);
        write_cfg(REG_SIZE_Y, 11'd1);
        write_cfg(REG_SIZE_Z, 11'd1024);
        cfg_we <= 1'b0;
        repeat (150) send_voxel(pick_word());
        in_valid <= 1'b0;
        total += 150;
        wait_drained();
        write_cfg(REG_SIZE_X, 11'd2047);
        write_cfg(REG_SIZE_Y, 11'd2047);
        cfg_we <= 1'b0;
        n = 20;
      end else begin
        if ($urandom_range(0, 2) != 0) write_cfg(REG_SIZE_X, pick_size());
        if ($urandom_range(0, 2) != 0) write_cfg(REG_SIZE_Y, pick_size());
        if ($urandom_range(0, 2) != 0) write_cfg(REG_SIZE_Z, pick_size());
        if ($urandom_range(0, 7) == 0) write_cfg(REG_UNUSED, SIZE_W'($urandom_range(0, 2047)));
        cfg_we <= 1'b0;
        n = $urandom_range(10, 90);
      end
      repeat (n) send_voxel(pick_word());
      in_valid <= 1'b0;
      total += n;
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
